### rtl/msfp_pkg.sv
// msfp_pkg: types and constants shared by the minimum spanning forest block
// no dependencies
`default_nettype none
package msfp_pkg;
    localparam int NODE_W  = 6;
    localparam int COST_W  = 16;
    localparam int TOTAL_W = 22;
    localparam int CNT_W   = 7;
    localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_LOAD,
        S_INIT,
        S_ROOT,
        S_RELAX,
        S_DECIDE,
        S_FINISH
    } t_state;

    // adjacency entry: present flag and cost
    typedef struct packed {
        logic              present;
        logic [COST_W-1:0] cost;
    } t_adj;

    // best crossing edge seen so far for one outside node
    typedef struct packed {
        logic              present;
        logic [COST_W-1:0] cost;
        logic [NODE_W-1:0] parent;
    } t_key;

    typedef struct packed {
        logic [NODE_W-1:0]  tree_low_node;
        logic [NODE_W-1:0]  tree_high_node;
        logic [COST_W-1:0]  tree_edge_cost;
        logic [TOTAL_W-1:0] running_total;
        logic               edge_valid;
    } t_result;
endpackage
`default_nettype wire

### rtl/msfp_if.sv
// msfp_edge_if / msfp_tree_if: valid-ready channels for edge beats and forest result beats
// depends on msfp_pkg
`default_nettype none
interface msfp_edge_if;
    import msfp_pkg::*;
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [COST_W-1:0] edge_cost;
    logic              edge_present;
    logic              last_edge;
    modport source (output valid, node_a, node_b, edge_cost, edge_present, last_edge,
                    input ready);
    modport sink   (input valid, node_a, node_b, edge_cost, edge_present, last_edge,
                    output ready);
endinterface

interface msfp_tree_if;
    import msfp_pkg::*;
    logic               valid;
    logic               ready;
    logic [NODE_W-1:0]  tree_low_node;
    logic [NODE_W-1:0]  tree_high_node;
    logic [COST_W-1:0]  tree_edge_cost;
    logic [TOTAL_W-1:0] running_total;
    logic               edge_valid;
    logic               last_result;
    modport source (output valid, tree_low_node, tree_high_node, tree_edge_cost,
                    running_total, edge_valid, last_result, input ready);
    modport sink   (input valid, tree_low_node, tree_high_node, tree_edge_cost,
                    running_total, edge_valid, last_result, output ready);
endinterface
`default_nettype wire

### rtl/msfp_adj_mem.sv
// msfp_adj_mem: adjacency cost memory, one entry per unordered node pair
// depends on msfp_pkg
`default_nettype none
module msfp_adj_mem
    import msfp_pkg::*;
#(
    parameter int AW = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_adj          i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_adj               o_rd_data
);
    t_adj r_mem [2**AW];
    t_adj r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

### rtl/msfp_key_mem.sv
// msfp_key_mem: per-node best crossing edge memory
// depends on msfp_pkg
`default_nettype none
module msfp_key_mem
    import msfp_pkg::*;
#(
    parameter int AW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_key          i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_key               o_rd_data
);
    t_key r_mem [2**AW];
    t_key r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule
`default_nettype wire

### rtl/min_spanning_forest_prim_core.sv
// min_spanning_forest_prim_core: Prim minimum spanning forest over a loaded edge list
// depends on msfp_pkg, msfp_if, msfp_adj_mem, msfp_key_mem
`default_nettype none
// Edge beats load one per cycle into an adjacency memory indexed by the unordered node pair.
// The beat with last_edge starts the run: keys for all n nodes are reset, then each tree
// node is relaxed against every node in one pass through the adjacency and key memories,
// and the cheapest outside node found in that same pass joins next. Results go out in join
// order with the running total; an empty forest gives one beat with edge_valid low. After
// each run, and after reset, a clearing pass wipes the adjacency memory with the edge input
// held off. node_count must be written only while idle; the block itself does not enforce it.
module min_spanning_forest_prim_core
    import msfp_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CNT_W-1:0] i_cfg_wr_data,
    msfp_edge_if.sink             i_edge,
    msfp_tree_if.source           o_tree
);
    localparam int IW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int AAW = 2 * IW;
    localparam logic [CNT_W-1:0] MAXN = CNT_W'(MAX_NODES);

    t_state r_state, n_state;
    logic [CNT_W-1:0]     r_node_count;
    logic [CW-1:0]        r_w, n_w;
    logic [CW-1:0]        r_root, n_root;
    logic [IW-1:0]        r_u, n_u;
    logic                 r_s1_vld, n_s1_vld;
    logic [IW-1:0]        r_s1_w, n_s1_w;
    logic [MAX_NODES-1:0] r_mask, n_mask;
    logic [TOTAL_W-1:0]   r_total, n_total;
    logic                 r_found, n_found;
    logic [IW-1:0]        r_pick, n_pick;
    t_key                 r_pick_key, n_pick_key;
    logic                 r_pend, n_pend;
    t_result              r_pend_res, n_pend_res;
    logic                 r_o_valid, n_o_valid;
    t_result              r_o_res, n_o_res;
    logic                 r_o_last, n_o_last;
    logic [AAW:0]         r_clr, n_clr;

    logic [CW-1:0] nodes;
    logic          out_free;
    logic          adj_we;
    logic [AAW-1:0] adj_waddr, adj_raddr;
    t_adj          adj_wdata, adj_rdata;
    logic          key_we;
    logic [IW-1:0] key_waddr, key_raddr;
    t_key          key_wdata, key_rdata;
    logic          edge_ok;
    logic [IW-1:0] ea, eb, lo_n, hi_n, wi;
    logic          upd;
    t_key          new_key;
    logic [TOTAL_W-1:0] sum;

    assign nodes = (r_node_count > MAXN) ? CW'(MAX_NODES) : CW'(r_node_count);
    assign out_free = !r_o_valid || o_tree.ready;
    assign i_edge.ready = (r_state == S_LOAD);

    assign ea = IW'(i_edge.node_a);
    assign eb = IW'(i_edge.node_b);
    assign edge_ok = i_edge.edge_present && (i_edge.node_a != i_edge.node_b)
                     && (CNT_W'(i_edge.node_a) < CNT_W'(nodes))
                     && (CNT_W'(i_edge.node_b) < CNT_W'(nodes));
    assign wi = r_w[IW-1:0];
    assign adj_raddr = (r_u < wi) ? {r_u, wi} : {wi, r_u};
    assign key_raddr = wi;
    assign sum = r_total + TOTAL_W'($signed(r_pick_key.cost));

    always_comb begin
        lo_n = (ea < eb) ? ea : eb;
        hi_n = (ea < eb) ? eb : ea;
        // relax stage: compare stored edge against the node's best key
        upd = !r_mask[r_s1_w] && adj_rdata.present &&
              (!key_rdata.present ||
               ($signed(adj_rdata.cost) < $signed(key_rdata.cost)) ||
               (adj_rdata.cost == key_rdata.cost && NODE_W'(r_u) < key_rdata.parent));
        new_key = upd ? '{present: 1'b1, cost: adj_rdata.cost, parent: NODE_W'(r_u)}
                      : key_rdata;
    end

    always_comb begin
        n_state = r_state;
        n_w = r_w;
        n_root = r_root;
        n_u = r_u;
        n_s1_vld = 1'b0;
        n_s1_w = r_s1_w;
        n_mask = r_mask;
        n_total = r_total;
        n_found = r_found;
        n_pick = r_pick;
        n_pick_key = r_pick_key;
        n_pend = r_pend;
        n_pend_res = r_pend_res;
        n_o_valid = r_o_valid && !o_tree.ready;
        n_o_res = r_o_res;
        n_o_last = r_o_last;
        n_clr = r_clr;
        adj_we = 1'b0;
        adj_waddr = {lo_n, hi_n};
        adj_wdata = '{present: 1'b1, cost: i_edge.edge_cost};
        key_we = 1'b0;
        key_waddr = wi;
        key_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                adj_we = 1'b1;
                adj_waddr = r_clr[AAW-1:0];
                adj_wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr[AAW-1:0] == '1) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_edge.valid) begin
                    adj_we = edge_ok;
                    if (i_edge.last_edge) begin
                        n_state = S_INIT;
                        n_w = '0;
                    end
                end
            end
            S_INIT: begin
                if (r_w < nodes) begin
                    key_we = 1'b1;
                    n_w = r_w + 1'b1;
                end else begin
                    n_state = S_ROOT;
                    n_root = '0;
                end
            end
            S_ROOT: begin
                if (r_root == nodes) begin
                    n_state = S_FINISH;
                end else if (r_mask[r_root[IW-1:0]]) begin
                    n_root = r_root + 1'b1;
                end else begin
                    n_mask[r_root[IW-1:0]] = 1'b1;
                    n_u = r_root[IW-1:0];
                    n_w = '0;
                    n_found = 1'b0;
                    n_state = S_RELAX;
                end
            end
            S_RELAX: begin
                if (r_w < nodes) begin
                    n_s1_vld = 1'b1;
                    n_s1_w = wi;
                    n_w = r_w + 1'b1;
                end else if (!r_s1_vld) begin
                    n_state = S_DECIDE;
                end
                if (r_s1_vld && !r_mask[r_s1_w]) begin
                    key_we = upd;
                    key_waddr = r_s1_w;
                    key_wdata = new_key;
                    // strict compare keeps the lowest node on a cost tie
                    if (new_key.present && (!r_found ||
                        $signed(new_key.cost) < $signed(r_pick_key.cost))) begin
                        n_found = 1'b1;
                        n_pick = r_s1_w;
                        n_pick_key = new_key;
                    end
                end
            end
            S_DECIDE: begin
                if (!r_found) begin
                    n_root = r_root + 1'b1;
                    n_state = S_ROOT;
                end else if (!r_pend || out_free) begin
                    if (r_pend) begin
                        n_o_valid = 1'b1;
                        n_o_res = r_pend_res;
                        n_o_last = 1'b0;
                    end
                    n_pend = 1'b1;
                    n_pend_res.tree_low_node = (NODE_W'(r_pick) < r_pick_key.parent)
                        ? NODE_W'(r_pick) : r_pick_key.parent;
                    n_pend_res.tree_high_node = (NODE_W'(r_pick) < r_pick_key.parent)
                        ? r_pick_key.parent : NODE_W'(r_pick);
                    n_pend_res.tree_edge_cost = r_pick_key.cost;
                    n_pend_res.running_total = sum;
                    n_pend_res.edge_valid = 1'b1;
                    n_total = sum;
                    n_mask[r_pick] = 1'b1;
                    n_u = r_pick;
                    n_w = '0;
                    n_found = 1'b0;
                    n_state = S_RELAX;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_last = 1'b1;
                    n_o_res = r_pend ? r_pend_res : '0;
                    n_pend = 1'b0;
                    n_mask = '0;
                    n_total = '0;
                    n_clr = '0;
                    n_state = S_CLEAR;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_node_count <= CNT_RESET;
            r_clr <= '0;
            r_mask <= '0;
            r_total <= '0;
            r_pend <= 1'b0;
            r_o_valid <= 1'b0;
            r_s1_vld <= 1'b0;
            r_found <= 1'b0;
            r_w <= '0;
            r_root <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_node_count <= i_cfg_wr_data;
            end
            r_clr <= n_clr;
            r_mask <= n_mask;
            r_total <= n_total;
            r_pend <= n_pend;
            r_o_valid <= n_o_valid;
            r_s1_vld <= n_s1_vld;
            r_found <= n_found;
            r_w <= n_w;
            r_root <= n_root;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= n_u;
        r_s1_w <= n_s1_w;
        r_pick <= n_pick;
        r_pick_key <= n_pick_key;
        r_pend_res <= n_pend_res;
        r_o_res <= n_o_res;
        r_o_last <= n_o_last;
    end

    msfp_adj_mem #(.AW(AAW)) u_adj (
        .i_clk     (i_clk),
        .i_wr_en   (adj_we),
        .i_wr_addr (adj_waddr),
        .i_wr_data (adj_wdata),
        .i_rd_addr (adj_raddr),
        .o_rd_data (adj_rdata)
    );

    msfp_key_mem #(.AW(IW)) u_key (
        .i_clk     (i_clk),
        .i_wr_en   (key_we),
        .i_wr_addr (key_waddr),
        .i_wr_data (key_wdata),
        .i_rd_addr (key_raddr),
        .o_rd_data (key_rdata)
    );

    assign o_tree.valid          = r_o_valid;
    assign o_tree.tree_low_node  = r_o_res.tree_low_node;
    assign o_tree.tree_high_node = r_o_res.tree_high_node;
    assign o_tree.tree_edge_cost = r_o_res.tree_edge_cost;
    assign o_tree.running_total  = r_o_res.running_total;
    assign o_tree.edge_valid     = r_o_res.edge_valid;
    assign o_tree.last_result    = r_o_last;

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tree.valid && !o_tree.edge_valid |-> o_tree.last_result)
        else $error("empty result beat without last_result");
    a_s1_in_relax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> r_state == S_RELAX)
        else $error("relax stage active outside relax pass");
    a_clear_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR && $past(r_state) == S_FINISH |-> r_mask == '0 && !r_pend)
        else $error("run state not cleared after finish");
endmodule
`default_nettype wire
